// File: design/sfd_pkg.sv
package sfd_pkg;

    // Frame layout
    localparam logic [7:0] HEADER_BYTE   = 8'h0F;
    localparam int         POS_W         = 5;
    localparam logic [POS_W-1:0] POS_HUNT     = 5'd0;
    localparam logic [POS_W-1:0] POS_FIRST    = 5'd1;
    localparam logic [POS_W-1:0] POS_LAST     = 5'd24;   // 25th byte of a frame
    localparam int         PAYLOAD_BYTES = 22;
    localparam int         PAYLOAD_IDX_W = $clog2(PAYLOAD_BYTES);
    localparam int         PAYLOAD_W     = 8 * PAYLOAD_BYTES;

    // Channel unpacking
    localparam int         CH_BITS       = 11;
    localparam int         CHANNELS      = 16;
    localparam int         CH_IDX_W      = $clog2(CHANNELS);
    localparam logic [CH_IDX_W-1:0] CH_IDX_LAST = CH_IDX_W'(CHANNELS - 1);

    // Frame queue between front and back
    localparam int         QUEUE_DEPTH   = 2;
    localparam int         QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int         QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    typedef logic [PAYLOAD_W-1:0] payload_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic not_empty;
        logic full;
    } queue_status_t;

endpackage

// File: design/sbus_frame_decoder_top.sv
// SBUS 16-channel frame decoder. Takes one received byte per accepted word
// on in_valid/in_ready and hunts for the 0x0F header, dropping other bytes.
// After a header it counts 24 more bytes; on the 25th the 22 payload bytes
// go into a two-frame queue and the block returns to hunting. The back end
// drains each queued frame as sixteen 11-bit channel words, LSB first,
// channel 0 first, with last_channel set on channel 15. Input runs at one
// byte per cycle; in_ready drops only while both queue slots hold frames.
// Output gives one channel per cycle while out_ready holds, sixteen per
// frame; an idle back end first loads the queued frame before its channels.
module sbus_frame_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  channel_index,
    output logic [10:0] channel_value,
    output logic        last_channel
);
    import sfd_pkg::*;

    queue_status_t q_status;
    logic          q_push;
    logic          q_pop;
    payload_t      push_data;
    payload_t      pop_data;

    sfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .q_status  (q_status),
        .push      (q_push),
        .push_data (push_data)
    );

    sfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    sfd_unpack u_unpack (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .pop_data      (pop_data),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .last_channel  (last_channel)
    );

    // A finished frame never meets a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_status.full))
        else $error("frame pushed into full queue");

    // The last flag marks channel 15 only
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_channel == (channel_index == CH_IDX_LAST)))
        else $error("last_channel does not match channel_index");

    // Within a frame the next channel follows right away
    a_next_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_channel)
        |=> (out_valid && channel_index == $past(channel_index) + 4'd1))
        else $error("channel sequence broken inside a frame");

    // Input is not ready while the queue is full
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !in_ready)
        else $error("input ready while queue full");

endmodule

// File: design/sfd_front.sv
module sfd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    input  sfd_pkg::queue_status_t q_status,
    output logic              push,
    output sfd_pkg::payload_t push_data
);
    import sfd_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       byte_reg [PAYLOAD_BYTES];
    logic             accept;
    logic [POS_W-1:0] wr_pos;
    logic             store;

    // Take a word whenever the queue has room for a finished frame
    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    // Byte position: 0 hunts for the header, 1..24 count frame bytes
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (pos_reg == POS_HUNT)
                pos_next = (rx_byte == HEADER_BYTE) ? POS_FIRST : POS_HUNT;
            else if (pos_reg == POS_LAST)
                pos_next = POS_HUNT;
            else
                pos_next = pos_reg + POS_FIRST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= POS_HUNT;
        else
            pos_reg <= pos_next;
    end

    // Payload bytes only; flag and footer are not needed downstream
    assign wr_pos = pos_reg - POS_FIRST;
    assign store  = accept && (pos_reg != POS_HUNT)
                    && (pos_reg <= POS_W'(PAYLOAD_BYTES));

    always_ff @(posedge clk)
    begin
        if (store)
            byte_reg[wr_pos[PAYLOAD_IDX_W-1:0]] <= rx_byte;
    end

    // Frame complete on the 25th byte
    assign push = accept && (pos_reg == POS_LAST);

    always_comb
    begin
        for (int i = 0; i < PAYLOAD_BYTES; i++)
            push_data[8*i +: 8] = byte_reg[i];
    end

endmodule

// File: design/sfd_queue.sv
module sfd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sfd_pkg::payload_t push_data,
    input  logic              pop,
    output sfd_pkg::payload_t pop_data,
    output sfd_pkg::queue_status_t status
);
    import sfd_pkg::*;

    payload_t               slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] cnt_reg, cnt_next;
    logic                   do_push, do_pop;

    assign status.not_empty = (cnt_reg != '0);
    assign status.full      = (cnt_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign do_push          = push && !status.full;
    assign do_pop           = pop && status.not_empty;
    assign pop_data         = slot_reg[rd_ptr_reg];

    // Pointer wrap and occupancy count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: design/sfd_unpack.sv
module sfd_unpack (
    input  logic              clk,
    input  logic              rst_n,
    input  sfd_pkg::queue_status_t q_status,
    input  sfd_pkg::payload_t pop_data,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [sfd_pkg::CH_IDX_W-1:0] channel_index,
    output logic [sfd_pkg::CH_BITS-1:0]  channel_value,
    output logic              last_channel
);
    import sfd_pkg::*;

    logic                busy_reg, busy_next;
    logic [CH_IDX_W-1:0] cnt_reg, cnt_next;
    payload_t            frame_reg;
    logic                out_valid_reg, out_valid_next;
    logic [CH_IDX_W-1:0] index_reg;
    logic [CH_BITS-1:0]  value_reg;
    logic                last_reg;
    logic                load;
    logic                finish;

    // Move one channel into the output register when it is free
    assign load   = busy_reg && (!out_valid_reg || out_ready);
    assign finish = load && (cnt_reg == CH_IDX_LAST);
    assign pop    = q_status.not_empty && (!busy_reg || finish);

    always_comb
    begin
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            cnt_next       = cnt_reg + 1'b1;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
        if (finish)
            busy_next = 1'b0;
        if (pop)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Frame shifts down one channel per load, LSB first
    always_ff @(posedge clk)
    begin
        if (pop)
            frame_reg <= pop_data;
        else if (load)
            frame_reg <= frame_reg >> CH_BITS;
        if (load)
        begin
            index_reg <= cnt_reg;
            value_reg <= frame_reg[CH_BITS-1:0];
            last_reg  <= (cnt_reg == CH_IDX_LAST);
        end
    end

    assign out_valid     = out_valid_reg;
    assign channel_index = index_reg;
    assign channel_value = value_reg;
    assign last_channel  = last_reg;

endmodule
